// ===== src/per_requester_page_allocator_macros.svh =====
// Assertion macros used by the checker of the page allocator.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef PER_REQUESTER_PAGE_ALLOCATOR_MACROS_SVH
`define PER_REQUESTER_PAGE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PRA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/pra_pkg.sv =====
// Package of the page allocator: sizes, codes, reset constants and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package pra_pkg;

	localparam int ADDR_W     = 32;
	localparam int ACT_W      = 2;
	localparam int STATUS_W   = 2;
	localparam int REQ_W      = 3;
	localparam int SRC_W      = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int PAGE_SHIFT = 12;
	localparam int PAGE_BYTES = 1 << PAGE_SHIFT;

	localparam int NUM_PAGES      = 32768;
	localparam int PAGE_W         = $clog2(NUM_PAGES);
	localparam int LINK_W         = PAGE_W + 1;
	localparam int LIST_W         = 3;
	localparam int NUM_REQUESTERS = 1 << LIST_W;

	// Width of a page count taken from a 33-bit byte span.
	localparam int PCNT_W = ADDR_W + 1 - PAGE_SHIFT;

	localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
	localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_INIT  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OOM      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_POOL_START = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_END   = 1'd1;

	localparam logic [ADDR_W-1:0] RST_START = 32'h8002_1000;
	localparam logic [ADDR_W-1:0] RST_END   = 32'h8800_0000;

	// Pool layout right after reset, identical to an initialization by list zero.
	localparam logic [ADDR_W:0] PAGE_MASK = (ADDR_W + 1)'(PAGE_BYTES - 1);
	localparam logic [ADDR_W:0] RST_BASE  = ({1'b0, RST_START} + PAGE_MASK) & ~PAGE_MASK;
	localparam logic [ADDR_W:0] RST_END_X = {1'b0, RST_END};
	localparam longint RST_SPAN =
		((RST_BASE + (ADDR_W + 1)'(PAGE_BYTES)) <= RST_END_X) ?
		longint'(RST_END_X - RST_BASE) / PAGE_BYTES : 64'sd0;
	localparam longint RST_PAGES = (RST_SPAN > NUM_PAGES) ? longint'(NUM_PAGES) : RST_SPAN;
	localparam logic [PAGE_W-1:0] RST_HEAD = PAGE_W'(RST_PAGES - 1);
	localparam logic RST_HEAD_VALID = (RST_PAGES != 0);

	typedef struct packed {
		logic latch_in;
		logic decode;
		logic sweep_step;
		logic alloc_rd;
		logic alloc_wb;
		logic free_wr;
		logic load_out;
	} pra_cmd_t;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic             alloc_none;
		logic             free_bad;
		logic             sweep_last;
		logic             out_free;
	} pra_stat_t;

endpackage

// ===== src/pra_if.sv =====
// Valid/ready channel interfaces for the page allocator's requests and responses.
// Depends on pra_pkg for the field widths.
`timescale 1ns / 1ps

interface pra_in_if;
	logic                           valid;
	logic                           ready;
	logic [pra_pkg::ACT_W-1:0]      action;
	logic [pra_pkg::REQ_W-1:0]      requester;
	logic [pra_pkg::ADDR_W-1:0]     address;

	modport source(output valid, output action, output requester, output address,
		input ready);
	modport sink(input valid, input action, input requester, input address,
		output ready);
endinterface

interface pra_out_if;
	logic                           valid;
	logic                           ready;
	logic [pra_pkg::STATUS_W-1:0]   status;
	logic [pra_pkg::ADDR_W-1:0]     page_addr;
	logic [pra_pkg::SRC_W-1:0]      source_list;

	modport source(output valid, output status, output page_addr, output source_list,
		input ready);
	modport sink(input valid, input status, input page_addr, input source_list,
		output ready);
endinterface

// ===== src/pra_ctrl.sv =====
// Controller of the page allocator: sequences each transaction and the link
// memory sweep. Depends on pra_pkg for the command and status structs.
`timescale 1ns / 1ps

module pra_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  pra_pkg::pra_stat_t stat,
	output pra_pkg::pra_cmd_t  cmd,
	output logic               in_ready
);

	typedef enum logic [7:0] {
		S_CLEAR    = 8'b0000_0001,
		S_IDLE     = 8'b0000_0010,
		S_DECODE   = 8'b0000_0100,
		S_SWEEP    = 8'b0000_1000,
		S_ALLOC_RD = 8'b0001_0000,
		S_ALLOC_WB = 8'b0010_0000,
		S_FREE_WR  = 8'b0100_0000,
		S_DONE     = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.sweep_step = 1'b1;
				if (stat.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				case (stat.action)
					pra_pkg::ACT_ALLOC: state_d = stat.alloc_none ? S_DONE : S_ALLOC_RD;
					pra_pkg::ACT_FREE:  state_d = stat.free_bad ? S_DONE : S_FREE_WR;
					pra_pkg::ACT_INIT:  state_d = S_SWEEP;
					default:            state_d = S_DONE;
				endcase
			end
			S_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (stat.sweep_last) begin
					state_d = S_DONE;
				end
			end
			S_ALLOC_RD: begin
				cmd.alloc_rd = 1'b1;
				state_d      = S_ALLOC_WB;
			end
			S_ALLOC_WB: begin
				cmd.alloc_wb = 1'b1;
				state_d      = S_DONE;
			end
			S_FREE_WR: begin
				cmd.free_wr = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

endmodule

// ===== src/pra_dp.sv =====
// Datapath of the page allocator: pool registers, list heads, link memory,
// bounds checks and the response register. Depends on pra_pkg.
`timescale 1ns / 1ps

module pra_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pra_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pra_pkg::ADDR_W-1:0]      cfg_data,
	input  logic [pra_pkg::ACT_W-1:0]       action,
	input  logic [pra_pkg::REQ_W-1:0]       requester,
	input  logic [pra_pkg::ADDR_W-1:0]      address,
	input  pra_pkg::pra_cmd_t               cmd,
	output pra_pkg::pra_stat_t              stat,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [pra_pkg::STATUS_W-1:0]    status,
	output logic [pra_pkg::ADDR_W-1:0]      page_addr,
	output logic [pra_pkg::SRC_W-1:0]       source_list
);

	localparam int AW = pra_pkg::ADDR_W;
	localparam int PW = pra_pkg::PAGE_W;
	localparam int LW = pra_pkg::LIST_W;
	localparam int CW = pra_pkg::PCNT_W;
	localparam int SH = pra_pkg::PAGE_SHIFT;

	logic [AW-1:0] start_q;
	logic [AW-1:0] end_q;

	logic [pra_pkg::ACT_W-1:0] act_q;
	logic [LW-1:0]             req_q;
	logic [AW-1:0]             addr_q;
	logic [LW-1:0]             sel_q;
	logic [PW-1:0]             page_q;
	logic [AW:0]               base_q;
	logic [PW-1:0]             cnt_q;

	logic [PW-1:0]                     head_q [pra_pkg::NUM_REQUESTERS];
	logic [pra_pkg::NUM_REQUESTERS-1:0] head_valid_q;

	logic [pra_pkg::LINK_W-1:0] link_mem [pra_pkg::NUM_PAGES];
	logic [pra_pkg::LINK_W-1:0] rd_q;

	logic [pra_pkg::STATUS_W-1:0] res_status_q;
	logic [AW-1:0]                res_page_q;
	logic [pra_pkg::SRC_W-1:0]    res_src_q;

	logic                         out_valid_q;
	logic [pra_pkg::STATUS_W-1:0] out_status_q;
	logic [AW-1:0]                out_page_q;
	logic [pra_pkg::SRC_W-1:0]    out_src_q;

	// Allocation source selection.
	logic          own_valid;
	logic          found;
	logic [LW-1:0] victim;
	logic [LW-1:0] alloc_sel;
	logic          alloc_none;

	// Free address checks.
	logic [AW:0]   addr_ext;
	logic [AW:0]   free_diff;
	logic [CW-1:0] free_pages;
	logic          free_bad;

	// Pool initialization.
	logic [AW:0]   base_new;
	logic [AW:0]   init_span;
	logic [CW-1:0] span_pages;
	logic [CW-1:0] init_pages;
	logic          init_ok;
	logic [PW-1:0] head_new;

	logic                       sweep_last;
	logic                       mem_we;
	logic [PW-1:0]              mem_waddr;
	logic [pra_pkg::LINK_W-1:0] mem_wdata;
	logic [PW-1:0]              sel_head;
	logic [AW:0]                alloc_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= pra_pkg::RST_START;
			end_q   <= pra_pkg::RST_END;
		end else if (cfg_we) begin
			case (cfg_index)
				pra_pkg::CFG_POOL_START: start_q <= cfg_data;
				pra_pkg::CFG_POOL_END:   end_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		own_valid = head_valid_q[req_q];
		found     = 1'b0;
		victim    = '0;
		for (int i = 0; i < pra_pkg::NUM_REQUESTERS; i++) begin
			if (!found && head_valid_q[i] && (LW'(i) != req_q)) begin
				victim = LW'(i);
				found  = 1'b1;
			end
		end
		alloc_sel  = own_valid ? req_q : victim;
		alloc_none = !own_valid && !found;
	end

	assign addr_ext   = {1'b0, addr_q};
	assign free_diff  = addr_ext - base_q;
	assign free_pages = free_diff[AW:SH];
	assign free_bad   = (addr_q[SH-1:0] != '0) || (addr_q < start_q) || (addr_q >= end_q) ||
		(addr_ext < base_q) || (free_pages >= CW'(pra_pkg::NUM_PAGES));

	assign base_new   = ({1'b0, start_q} + pra_pkg::PAGE_MASK) & ~pra_pkg::PAGE_MASK;
	assign init_ok    = (base_new + (AW + 1)'(pra_pkg::PAGE_BYTES)) <= {1'b0, end_q};
	assign init_span  = {1'b0, end_q} - base_new;
	assign span_pages = init_span[AW:SH];
	assign init_pages = (span_pages > CW'(pra_pkg::NUM_PAGES)) ?
		CW'(pra_pkg::NUM_PAGES) : span_pages;
	assign head_new   = PW'(init_pages - CW'(1));

	assign sweep_last = (cnt_q == PW'(pra_pkg::NUM_PAGES - 1));
	assign sel_head   = head_q[sel_q];
	assign alloc_addr = base_q + (AW + 1)'({page_q, {SH{1'b0}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pra_pkg::NUM_REQUESTERS; i++) begin
				head_q[i] <= (i == 0) ? pra_pkg::RST_HEAD : '0;
			end
			head_valid_q <= pra_pkg::NUM_REQUESTERS'(pra_pkg::RST_HEAD_VALID);
			base_q       <= pra_pkg::RST_BASE;
			cnt_q        <= '0;
		end else begin
			if (cmd.decode && (act_q == pra_pkg::ACT_INIT)) begin
				base_q        <= base_new;
				head_valid_q  <= init_ok ? (pra_pkg::NUM_REQUESTERS'(1) << req_q) : '0;
				head_q[req_q] <= head_new;
			end
			if (cmd.alloc_wb) begin
				head_q[sel_q]       <= rd_q[PW-1:0];
				head_valid_q[sel_q] <= rd_q[PW];
			end
			if (cmd.free_wr) begin
				head_q[sel_q]       <= page_q;
				head_valid_q[sel_q] <= 1'b1;
			end
			if (cmd.sweep_step) begin
				cnt_q <= sweep_last ? '0 : cnt_q + PW'(1);
			end
		end
	end

	// The sweep rebuilds the descending chain through every entry; entries past
	// the pool's page count are only read after a free has rewritten them.
	always_comb begin
		mem_we    = cmd.sweep_step || cmd.free_wr;
		mem_waddr = cmd.free_wr ? page_q : cnt_q;
		mem_wdata = cmd.free_wr ? {head_valid_q[sel_q], sel_head} :
			{(cnt_q != '0), cnt_q - PW'(1)};
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.alloc_rd) begin
			rd_q <= link_mem[sel_head];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			act_q  <= action;
			req_q  <= requester[LW-1:0];
			addr_q <= address;
		end
		if (cmd.decode) begin
			res_page_q <= '0;
			res_src_q  <= '0;
			case (act_q)
				pra_pkg::ACT_ALLOC: begin
					sel_q        <= alloc_sel;
					res_status_q <= alloc_none ? pra_pkg::ST_OOM : pra_pkg::ST_OK;
				end
				pra_pkg::ACT_FREE: begin
					sel_q        <= req_q;
					page_q       <= free_pages[PW-1:0];
					res_status_q <= free_bad ? pra_pkg::ST_BAD_FREE : pra_pkg::ST_OK;
				end
				default: begin
					res_status_q <= pra_pkg::ST_OK;
				end
			endcase
		end
		if (cmd.alloc_rd) begin
			page_q <= sel_head;
		end
		if (cmd.alloc_wb) begin
			res_page_q <= alloc_addr[AW-1:0];
			res_src_q  <= pra_pkg::SRC_W'(sel_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_page_q   <= res_page_q;
			out_src_q    <= res_src_q;
		end
	end

	assign stat.action     = act_q;
	assign stat.alloc_none = alloc_none;
	assign stat.free_bad   = free_bad;
	assign stat.sweep_last = sweep_last;
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign page_addr   = out_page_q;
	assign source_list = out_src_q;

endmodule

// ===== src/per_requester_page_allocator.sv =====
// Page allocator with one LIFO free list of 4096-byte pages per requester, the
// lists linked through a single-port link memory of one entry per page. Each
// request transaction yields exactly one response transaction. An allocate
// goes from acceptance to a loaded response through decode, link memory read,
// head update and response, a free through decode, link memory write and
// response, and a rejected free, an empty pool or an unused action through
// decode and response; the link memory read is registered, hence its own read
// step. After loading a response the controller returns to idle, where it
// accepts the next request. Initialize rewrites every link memory entry, one
// per cycle. After reset the same sweep runs before the first request is
// accepted; configuration writes are taken during it. A new request is
// accepted while the previous response still waits. Depends on pra_pkg, the
// channel interfaces, pra_ctrl and pra_dp.
`timescale 1ns / 1ps

module per_requester_page_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pra_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pra_pkg::ADDR_W-1:0]    cfg_data,
	pra_in_if.sink                        request,
	pra_out_if.source                     response
);

	pra_pkg::pra_cmd_t  cmd;
	pra_pkg::pra_stat_t stat;

	pra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (request.valid),
		.stat     (stat),
		.cmd      (cmd),
		.in_ready (request.ready)
	);

	pra_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.action      (request.action),
		.requester   (request.requester),
		.address     (request.address),
		.cmd         (cmd),
		.stat        (stat),
		.out_ready   (response.ready),
		.out_valid   (response.valid),
		.status      (response.status),
		.page_addr   (response.page_addr),
		.source_list (response.source_list)
	);

endmodule

// ===== src/pra_checker.sv =====
// Port-level checker for the page allocator and the bind that attaches it.
// Depends on pra_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "per_requester_page_allocator_macros.svh"

module pra_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [pra_pkg::STATUS_W-1:0] status,
	input logic [pra_pkg::ADDR_W-1:0]   page_addr,
	input logic [pra_pkg::SRC_W-1:0]    source_list
);

	logic in_acc;

	assign in_acc = in_valid && in_ready;

	// A stalled response must stay offered.
	`PRA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "response dropped while stalled")

	// A failed request never reports a page or a source list.
	`PRA_ASSERT_NOW(a_fail_zero, clk, arst_n, out_valid && (status != pra_pkg::ST_OK), (page_addr == '0) && (source_list == '0), "failed response carries a page")

	// One transaction is worked at a time, so acceptance closes the request side.
	`PRA_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_acc, !in_ready, "request accepted while busy")

	// The link memory sweep after reset keeps the request side closed.
	`PRA_ASSERT_NOW(a_clear_after_reset, clk, arst_n, !$past(arst_n), !in_ready, "request accepted during reset sweep")

endmodule

bind per_requester_page_allocator pra_checker u_pra_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (request.valid),
	.in_ready    (request.ready),
	.out_valid   (response.valid),
	.out_ready   (response.ready),
	.status      (response.status),
	.page_addr   (response.page_addr),
	.source_list (response.source_list)
);

// ===== tb/sv/tb.sv =====
// Self-checking bench for the per-requester page allocator: a directed table,
// then random phases under several pool settings, checked against a local model.
// Depends on pra_pkg, the pra_in_if/pra_out_if interfaces and the allocator top.
`timescale 1ns / 1ps

module tb;
	import pra_pkg::*;

	localparam int XW = ADDR_W + 1;
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
	localparam int ITEMS_PER_PHASE = 135;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 200000;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   page_addr;
		logic [SRC_W-1:0]    source_list;
	} resp_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;
	typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;

	typedef struct {
		row_kind_e            kind;
		logic [ACT_W-1:0]     act;
		logic [REQ_W-1:0]     req;
		logic [ADDR_W-1:0]    value;
		logic [CFG_IDX_W-1:0] reg_idx;
		bit                   typed;
		resp_t                want;
	} row_t;

	typedef struct {
		logic [ADDR_W-1:0] pool_lo;
		logic [ADDR_W-1:0] pool_hi;
		bit                reinit;
		bit                rand_pool;
	} phase_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ADDR_W-1:0] cfg_data;

	pra_in_if  request_ch();
	pra_out_if response_ch();

	per_requester_page_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.request  (request_ch),
		.response (response_ch)
	);

	// Local copy of the allocator: free lists, link memory and registers.
	logic [PAGE_W-1:0] link_next [NUM_PAGES];
	bit                link_ok   [NUM_PAGES];
	logic [PAGE_W-1:0] head_page [NUM_REQUESTERS];
	bit                head_ok   [NUM_REQUESTERS];
	logic [XW-1:0]     base_latch;
	logic [ADDR_W-1:0] cfg_start;
	logic [ADDR_W-1:0] cfg_end;

	resp_t awaited_q [$];
	logic [ADDR_W-1:0] held_pages [$];
	int unsigned mismatches = 0;
	idle_e idle_mode = IDLE_NONE;
	bit hold_on = 1'b0;
	event hold_go;

	row_t directed_rows [$] = '{
		'{ROW_ITEM, ACT_ALLOC,  3'd0, 32'h0000_0000, CFG_POOL_START, 1'b1,
			'{ST_OK, 32'h87FF_F000, 3'd0}},
		'{ROW_ITEM, ACT_ALLOC,  3'd3, 32'h0000_0000, CFG_POOL_START, 1'b1,
			'{ST_OK, 32'h87FF_E000, 3'd0}},
		'{ROW_ITEM, ACT_FREE,   3'd1, 32'h8002_1001, CFG_POOL_START, 1'b1,
			'{ST_BAD_FREE, 32'h0, 3'd0}},
		'{ROW_ITEM, ACT_FREE,   3'd1, 32'h8002_0000, CFG_POOL_START, 1'b1,
			'{ST_BAD_FREE, 32'h0, 3'd0}},
		'{ROW_ITEM, ACT_FREE,   3'd1, 32'h8800_0000, CFG_POOL_START, 1'b1,
			'{ST_BAD_FREE, 32'h0, 3'd0}},
		'{ROW_ITEM, ACT_FREE,   3'd2, 32'hFFFF_F000, CFG_POOL_START, 1'b1,
			'{ST_BAD_FREE, 32'h0, 3'd0}},
		'{ROW_ITEM, ACT_UNUSED, 3'd7, 32'hFFFF_FFFF, CFG_POOL_START, 1'b1,
			'{ST_OK, 32'h0, 3'd0}},
		'{ROW_ITEM, ACT_FREE,   3'd5, 32'h87FF_F000, CFG_POOL_START, 1'b1,
			'{ST_OK, 32'h0, 3'd0}},
		'{ROW_ITEM, ACT_ALLOC,  3'd5, 32'h0000_0000, CFG_POOL_START, 1'b1,
			'{ST_OK, 32'h87FF_F000, 3'd5}},
		'{ROW_ITEM, ACT_ALLOC,  3'd6, 32'h0000_0000, CFG_POOL_START, 1'b1,
			'{ST_OK, 32'h87FF_D000, 3'd0}},
		'{ROW_ITEM, ACT_FREE,   3'd7, 32'h8002_1000, CFG_POOL_START, 1'b1,
			'{ST_OK, 32'h0, 3'd0}},
		// The same page freed twice goes onto the list twice.
		'{ROW_ITEM, ACT_FREE,   3'd7, 32'h8002_1000, CFG_POOL_START, 1'b0,
			'{ST_OK, 32'h0, 3'd0}},
		'{ROW_ITEM, ACT_ALLOC,  3'd7, 32'h0000_0000, CFG_POOL_START, 1'b0,
			'{ST_OK, 32'h0, 3'd0}},
		'{ROW_CFG,  ACT_ALLOC,  3'd0, 32'h0000_1001, CFG_POOL_START, 1'b0,
			'{ST_OK, 32'h0, 3'd0}},
		'{ROW_CFG,  ACT_ALLOC,  3'd0, 32'h0000_5000, CFG_POOL_END,   1'b0,
			'{ST_OK, 32'h0, 3'd0}},
		'{ROW_ITEM, ACT_INIT,   3'd4, 32'h0000_0000, CFG_POOL_START, 1'b1,
			'{ST_OK, 32'h0, 3'd0}},
		'{ROW_ITEM, ACT_ALLOC,  3'd1, 32'h0000_0000, CFG_POOL_START, 1'b1,
			'{ST_OK, 32'h0000_4000, 3'd4}},
		'{ROW_ITEM, ACT_ALLOC,  3'd4, 32'h0000_0000, CFG_POOL_START, 1'b1,
			'{ST_OK, 32'h0000_3000, 3'd4}},
		'{ROW_ITEM, ACT_ALLOC,  3'd4, 32'h0000_0000, CFG_POOL_START, 1'b1,
			'{ST_OK, 32'h0000_2000, 3'd4}},
		'{ROW_ITEM, ACT_ALLOC,  3'd6, 32'h0000_0000, CFG_POOL_START, 1'b1,
			'{ST_OOM, 32'h0, 3'd0}},
		'{ROW_ITEM, ACT_FREE,   3'd3, 32'h0000_2000, CFG_POOL_START, 1'b1,
			'{ST_OK, 32'h0, 3'd0}},
		'{ROW_ITEM, ACT_ALLOC,  3'd0, 32'h0000_0000, CFG_POOL_START, 1'b0,
			'{ST_OK, 32'h0, 3'd0}},
		// Start lowered without a new init: the latched base still rejects this page.
		'{ROW_CFG,  ACT_ALLOC,  3'd0, 32'h0000_0000, CFG_POOL_START, 1'b0,
			'{ST_OK, 32'h0, 3'd0}},
		'{ROW_ITEM, ACT_FREE,   3'd2, 32'h0000_1000, CFG_POOL_START, 1'b1,
			'{ST_BAD_FREE, 32'h0, 3'd0}},
		'{ROW_CFG,  ACT_ALLOC,  3'd0, 32'hFFFF_FFFF, CFG_POOL_END,   1'b0,
			'{ST_OK, 32'h0, 3'd0}},
		'{ROW_ITEM, ACT_INIT,   3'd7, 32'h0000_0000, CFG_POOL_START, 1'b1,
			'{ST_OK, 32'h0, 3'd0}},
		'{ROW_ITEM, ACT_FREE,   3'd1, 32'h0800_0000, CFG_POOL_START, 1'b1,
			'{ST_BAD_FREE, 32'h0, 3'd0}},
		'{ROW_ITEM, ACT_FREE,   3'd1, 32'h07FF_F000, CFG_POOL_START, 1'b0,
			'{ST_OK, 32'h0, 3'd0}},
		// A start that rounds past the top of the address space leaves no pages.
		'{ROW_CFG,  ACT_ALLOC,  3'd0, 32'hFFFF_FFFF, CFG_POOL_START, 1'b0,
			'{ST_OK, 32'h0, 3'd0}},
		'{ROW_ITEM, ACT_INIT,   3'd2, 32'h0000_0000, CFG_POOL_START, 1'b1,
			'{ST_OK, 32'h0, 3'd0}},
		'{ROW_ITEM, ACT_ALLOC,  3'd2, 32'h0000_0000, CFG_POOL_START, 1'b1,
			'{ST_OOM, 32'h0, 3'd0}}
	};

	phase_t pool_phases [$] = '{
		'{32'h8002_1000, 32'h8800_0000, 1'b1, 1'b0},
		'{32'h0000_1001, 32'h0000_9000, 1'b1, 1'b0},
		'{32'h1000_0000, 32'h1001_0000, 1'b1, 1'b0},
		'{32'h0FFF_F000, 32'h1000_8000, 1'b0, 1'b0},
		'{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0},
		'{32'hFFFF_0000, 32'hFFFF_FFFF, 1'b1, 1'b0},
		'{32'h0000_0000, 32'h0000_4000, 1'b1, 1'b0},
		'{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1},
		'{32'h1234_5000, 32'h0000_0000, 1'b1, 1'b0}
	};

	function automatic void rebuild_pool(input int list);
		logic [XW-1:0] rounded;
		longint span_pages;
		int p;
		rounded = ({1'b0, cfg_start} + XW'(PAGE_BYTES - 1)) & ~XW'(PAGE_BYTES - 1);
		base_latch = rounded;
		span_pages = 0;
		for (p = 0; p < NUM_REQUESTERS; p++) begin
			head_page[p] = '0;
			head_ok[p] = 1'b0;
		end
		for (p = 0; p < NUM_PAGES; p++) begin
			link_next[p] = '0;
			link_ok[p] = 1'b0;
		end
		if (rounded + XW'(PAGE_BYTES) <= {1'b0, cfg_end}) begin
			span_pages = longint'(({1'b0, cfg_end} - rounded) >> PAGE_SHIFT);
		end
		if (span_pages > NUM_PAGES) begin
			span_pages = NUM_PAGES;
		end
		for (p = 0; p < span_pages; p++) begin
			link_next[p] = head_page[list];
			link_ok[p] = head_ok[list];
			head_page[list] = PAGE_W'(p);
			head_ok[list] = 1'b1;
		end
	endfunction

	function automatic bit take_page(input int list, output logic [PAGE_W-1:0] page);
		page = '0;
		if (!head_ok[list]) begin
			return 1'b0;
		end
		page = head_page[list];
		head_page[list] = link_next[page];
		head_ok[list] = link_ok[page];
		return 1'b1;
	endfunction

	function automatic resp_t serve_request(input logic [ACT_W-1:0] act,
		input logic [REQ_W-1:0] req, input logic [ADDR_W-1:0] addr);
		resp_t r;
		logic [PAGE_W-1:0] pg;
		logic [XW-1:0] offs;
		bit got;
		bit bad;
		int list;
		int from;
		r = '{ST_OK, '0, '0};
		list = int'(req) % NUM_REQUESTERS;
		case (act)
			ACT_ALLOC: begin
				got = take_page(list, pg);
				from = list;
				// Steal from the lowest-numbered other list that still has a page.
				for (int l = 0; l < NUM_REQUESTERS; l++) begin
					if (!got && l != list) begin
						if (take_page(l, pg)) begin
							got = 1'b1;
							from = l;
						end
					end
				end
				if (got) begin
					r.page_addr = ADDR_W'(base_latch + (XW'(pg) << PAGE_SHIFT));
					r.source_list = SRC_W'(from);
				end else begin
					r.status = ST_OOM;
				end
			end
			ACT_FREE: begin
				offs = {1'b0, addr} - base_latch;
				bad = addr[PAGE_SHIFT-1:0] != '0 || addr < cfg_start || addr >= cfg_end ||
					{1'b0, addr} < base_latch || (offs >> PAGE_SHIFT) >= XW'(NUM_PAGES);
				if (bad) begin
					r.status = ST_BAD_FREE;
				end else begin
					pg = PAGE_W'(offs >> PAGE_SHIFT);
					link_next[pg] = head_page[list];
					link_ok[pg] = head_ok[list];
					head_page[list] = pg;
					head_ok[list] = 1'b1;
				end
			end
			ACT_INIT: begin
				rebuild_pool(list);
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic flag(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		mismatches++;
	endtask

	// Offers one request and returns at the edge where it is accepted.
	task automatic send_item(input logic [ACT_W-1:0] act, input logic [REQ_W-1:0] req,
		input logic [ADDR_W-1:0] addr, input bit typed, input resp_t want);
		resp_t predicted;
		while ((idle_mode == IDLE_SEND && $urandom_range(0, 99) < 65) ||
			(idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 14)) begin
			request_ch.valid <= 1'b0;
			@(posedge clk);
		end
		request_ch.valid <= 1'b1;
		request_ch.action <= act;
		request_ch.requester <= req;
		request_ch.address <= addr;
		@(posedge clk);
		while (!request_ch.ready) begin
			@(posedge clk);
		end
		predicted = serve_request(act, req, addr);
		awaited_q.push_back(typed ? want : predicted);
		if (act == ACT_ALLOC && predicted.status == ST_OK) begin
			held_pages.push_back(predicted.page_addr);
		end
	endtask

	task automatic wait_drained();
		request_ch.valid <= 1'b0;
		while (awaited_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_POOL_START) begin
			cfg_start = data;
		end else begin
			cfg_end = data;
		end
		@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		forever begin
			@(hold_go);
			hold_on <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_on <= 1'b0;
		end
	end

	always @(posedge clk) begin
		response_ch.ready <= !hold_on &&
			!(idle_mode == IDLE_RECV && $urandom_range(0, 99) < 65) &&
			!(idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 14);
	end

	always @(posedge clk) begin
		resp_t want;
		if (arst_n && response_ch.valid && response_ch.ready) begin
			if (awaited_q.size() == 0) begin
				flag("response transaction with nothing outstanding");
			end else begin
				want = awaited_q.pop_front();
				if (response_ch.status !== want.status) begin
					flag($sformatf("status got %0d, wanted %0d", response_ch.status, want.status));
				end
				if (response_ch.page_addr !== want.page_addr) begin
					flag($sformatf("page_addr got %h, wanted %h",
						response_ch.page_addr, want.page_addr));
				end
				if (response_ch.source_list !== want.source_list) begin
					flag($sformatf("source_list got %0d, wanted %0d",
						response_ch.source_list, want.source_list));
				end
			end
		end
	end

	// The reset sweep and every init leave long quiet stretches, so the limit is generous.
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((request_ch.valid && request_ch.ready) ||
				(response_ch.valid && response_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
		$display("tb NOT OK");
		$finish;
	end

	initial begin
		phase_t ph;
		logic [ACT_W-1:0] act;
		logic [REQ_W-1:0] req;
		logic [ADDR_W-1:0] addr;
		int pick;
		int idx;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_POOL_START;
		cfg_data = '0;
		request_ch.valid = 1'b0;
		request_ch.action = ACT_ALLOC;
		request_ch.requester = '0;
		request_ch.address = '0;
		response_ch.ready = 1'b0;
		cfg_start = RST_START;
		cfg_end = RST_END;
		rebuild_pool(0);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				wait_drained();
				write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
			end else begin
				send_item(directed_rows[i].act, directed_rows[i].req, directed_rows[i].value,
					directed_rows[i].typed, directed_rows[i].want);
			end
		end

		foreach (pool_phases[p]) begin
			ph = pool_phases[p];
			if (ph.rand_pool) begin
				ph.pool_lo = $urandom;
				ph.pool_hi = ph.pool_lo + ($urandom_range(0, 48) << PAGE_SHIFT) +
					$urandom_range(0, 4095) - 32'd2048;
			end
			wait_drained();
			write_reg(CFG_POOL_START, ph.pool_lo);
			write_reg(CFG_POOL_END, ph.pool_hi);
			idle_mode = idle_e'(p % 4);
			if (ph.reinit) begin
				send_item(ACT_INIT, REQ_W'($urandom_range(0, 7)), $urandom, 1'b0, '0);
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (p == 0 && n == 20) begin
					-> hold_go;
				end
				if (n == ITEMS_PER_PHASE / 2) begin
					wait_drained();
				end
				req = REQ_W'($urandom_range(0, 7));
				act = ACT_FREE;
				addr = $urandom;
				pick = $urandom_range(0, 99);
				if (pick < 45 || (pick < 75 && held_pages.size() == 0)) begin
					act = ACT_ALLOC;
				end else if (pick < 75) begin
					idx = $urandom_range(0, held_pages.size() - 1);
					addr = held_pages[idx];
					// Now and then the page stays held so it gets freed twice.
					if ($urandom_range(0, 9) != 0) begin
						held_pages.delete(idx);
					end
				end else if (pick < 80) begin
					addr = (cfg_start & 32'hFFFF_F000) + ($urandom_range(0, 48) << PAGE_SHIFT) -
						32'h0000_8000;
				end else if (pick < 85) begin
					case ($urandom_range(0, 5))
						0: addr = cfg_start;
						1: addr = cfg_end;
						2: addr = cfg_end - PAGE_BYTES;
						3: addr = cfg_start & 32'hFFFF_F000;
						4: addr = ADDR_W'(base_latch) + ADDR_W'(NUM_PAGES * PAGE_BYTES);
						default: addr = ADDR_W'(base_latch) +
							ADDR_W'((NUM_PAGES - 1) * PAGE_BYTES);
					endcase
				end else if (pick < 91) begin
					addr = $urandom & 32'hFFFF_F000;
				end else if (pick < 95) begin
					act = ACT_UNUSED;
				end
				send_item(act, req, addr, 1'b0, '0);
			end
		end

		wait_drained();
		repeat (16) @(posedge clk);
		if (awaited_q.size() != 0) begin
			flag($sformatf("%0d responses never arrived", awaited_q.size()));
		end
		if (mismatches == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
